[rtl/asc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Aliquot sum classifier package
// Shared widths, codes, state encoding and the command and status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package asc_pkg;

    // Width of the number field on the input word.
    localparam int NUMBER_W        = 16;
    // Widths of the result fields.
    localparam int SUM_W           = 18;
    localparam int CLASS_W         = 2;
    // Word widths on the two stream ports, padded to whole bytes.
    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 24;
    // Bit positions of the result fields in the output word.
    localparam int SUM_LSB         = 0;
    localparam int CLASS_LSB       = SUM_LSB + SUM_W;
    localparam int PAD_LSB         = CLASS_LSB + CLASS_W;
    // Default working width of the number.
    localparam int VALUE_BITS_DEF  = 16;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_DEFICIENT = 2'd0,
        CLASS_PERFECT   = 2'd1,
        CLASS_ABUNDANT  = 2'd2
    } class_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new number and clear the running sum
        logic start;     // prime the remainder unit for the first candidate
        logic run;       // advance the remainder unit by one quotient bit
        logic out_load;  // copy the finished result into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic half_zero; // no candidate to try (number is zero or one)
        logic step_done; // remainder for the current candidate is complete
        logic cand_last; // current candidate is the last one, number / 2
    } dp_status_t;

endpackage
`default_nettype wire

[rtl/asc_rem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Aliquot sum classifier: remainder unit
// Restoring division, one quotient bit per run cycle, reporting whether the
// divisor leaves a zero remainder. Re-arms itself at the end of each division.
// ----------------------------------------------------------------------------
module asc_rem #(
    parameter int NB = 16
) (
    input  wire logic          aclk,
    input  wire logic          start,
    input  wire logic          run,
    input  wire logic [NB-1:0] dividend,
    input  wire logic [NB-1:0] divisor,
    output logic               done,
    output logic               rem_zero
);

    localparam int CW = $clog2(NB);

    logic [NB-1:0] rem_reg;
    logic [NB-1:0] dvd_reg;
    logic [CW-1:0] cnt_reg;

    logic [NB:0]   shifted;
    logic [NB+1:0] diff;
    logic [NB-1:0] rem_step;

    always_comb begin
        shifted  = {rem_reg, dvd_reg[NB-1]};
        diff     = {1'b0, shifted} - {2'b00, divisor};
        // A borrow means the divisor did not fit; keep the shifted remainder.
        rem_step = diff[NB+1] ? shifted[NB-1:0] : diff[NB-1:0];
        done     = run && (cnt_reg == CW'(NB - 1));
        rem_zero = (rem_step == '0);
    end

    always_ff @(posedge aclk) begin
        if (start || done) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            cnt_reg <= '0;
        end else if (run) begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[NB-2:0], 1'b0};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule
`default_nettype wire

[rtl/asc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Aliquot sum classifier: datapath
// Holds the number, the trial candidate and the running sum, drives the
// remainder unit and keeps the output result register.
// ----------------------------------------------------------------------------
module asc_dp #(
    parameter int NB = 16
) (
    input  wire logic                         aclk,
    input  wire asc_pkg::ctrl_cmd_t           cmd,
    input  wire logic [asc_pkg::NUMBER_W-1:0] number,
    output asc_pkg::dp_status_t               status,
    output logic [asc_pkg::SUM_W-1:0]         divisor_sum,
    output asc_pkg::class_t                   number_class
);

    // The proper divisor sum stays below four times the number in range.
    localparam int WSUM = NB + 2;

    logic [NB-1:0]   n_reg;
    logic [NB-2:0]   cand_reg;
    logic [WSUM-1:0] sum_reg;
    logic [asc_pkg::SUM_W-1:0] out_sum_reg;
    asc_pkg::class_t           out_class_reg;

    logic [NB-2:0]   half;
    logic            rem_done;
    logic            rem_zero;
    logic [WSUM-1:0] n_ext;
    asc_pkg::class_t cls;

    asc_rem #(
        .NB       (NB)
    ) u_rem (
        .aclk     (aclk),
        .start    (cmd.start),
        .run      (cmd.run),
        .dividend (n_reg),
        .divisor  ({1'b0, cand_reg}),
        .done     (rem_done),
        .rem_zero (rem_zero)
    );

    always_comb begin
        half             = n_reg[NB-1:1];
        n_ext            = WSUM'(n_reg);
        status.half_zero = (half == '0);
        status.step_done = rem_done;
        status.cand_last = (cand_reg == half);
        if (sum_reg < n_ext) begin
            cls = asc_pkg::CLASS_DEFICIENT;
        end else if (sum_reg == n_ext) begin
            cls = asc_pkg::CLASS_PERFECT;
        end else begin
            cls = asc_pkg::CLASS_ABUNDANT;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg    <= number[NB-1:0];
            cand_reg <= (NB-1)'(1);
            sum_reg  <= '0;
        end else if (cmd.run && rem_done) begin
            if (rem_zero) begin
                sum_reg <= sum_reg + WSUM'(cand_reg);
            end
            cand_reg <= cand_reg + 1'b1;
        end
        if (cmd.out_load) begin
            out_sum_reg   <= asc_pkg::SUM_W'(sum_reg);
            out_class_reg <= cls;
        end
    end

    assign divisor_sum  = out_sum_reg;
    assign number_class = out_class_reg;

endmodule
`default_nettype wire

[rtl/asc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Aliquot sum classifier: controller
// Sequences one number through setup, the trial divisions and the hand-over
// to the output register, and owns the handshake flags of both ports.
// ----------------------------------------------------------------------------
module asc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire asc_pkg::dp_status_t status,
    output asc_pkg::ctrl_cmd_t       cmd
);

    asc_pkg::state_t state_reg;
    asc_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            asc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = asc_pkg::ST_SETUP;
                end
            end
            asc_pkg::ST_SETUP: begin
                state_next = status.half_zero ? asc_pkg::ST_FINISH : asc_pkg::ST_DIVIDE;
            end
            asc_pkg::ST_DIVIDE: begin
                if (status.step_done && status.cand_last) begin
                    state_next = asc_pkg::ST_FINISH;
                end
            end
            asc_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = asc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = asc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.start    = 1'b0;
        cmd.run      = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            asc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            asc_pkg::ST_SETUP: begin
                cmd.start = 1'b1;
            end
            asc_pkg::ST_DIVIDE: begin
                cmd.run = 1'b1;
            end
            asc_pkg::ST_FINISH: begin
                cmd.out_load = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= asc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

[rtl/aliquot_sum_classifier.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Aliquot sum classifier
// Sums the proper divisors of a number by trial division and classifies the
// number as deficient, perfect or abundant.
// ----------------------------------------------------------------------------
// Each input word carries one number; only its low VALUE_BITS bits (at most
// sixteen) are used. The block tries every candidate from 1 to number / 2
// and adds those that divide evenly; each trial is a restoring division that
// produces one quotient bit per cycle; zero and one skip the trial divisions.
// The block works on one number at a time and is ready again as soon as its
// result has moved into the output register, so a result still waiting on
// m_tready does not hold up the next number. Zero gives a sum of zero and the
// class perfect; one gives a sum of zero and the class deficient.
// ----------------------------------------------------------------------------
module aliquot_sum_classifier #(
    parameter int VALUE_BITS = asc_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [asc_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] number
    // Result stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [asc_pkg::M_TDATA_W-1:0]      m_tdata    // [17:0] divisor_sum,
                                                          // [19:18] number_class,
                                                          // [23:20] zero
);

    // The number field is sixteen bits wide, so wider settings work at sixteen.
    localparam int NB = (VALUE_BITS < asc_pkg::NUMBER_W) ? VALUE_BITS : asc_pkg::NUMBER_W;

    asc_pkg::ctrl_cmd_t        cmd;
    asc_pkg::dp_status_t       status;
    logic [asc_pkg::SUM_W-1:0] divisor_sum;
    asc_pkg::class_t           number_class;

    asc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    asc_dp #(
        .NB           (NB)
    ) u_dp (
        .aclk         (aclk),
        .cmd          (cmd),
        .number       (s_tdata[asc_pkg::NUMBER_W-1:0]),
        .status       (status),
        .divisor_sum  (divisor_sum),
        .number_class (number_class)
    );

    // Fields packed from the lowest bit up, padding bits held at zero.
    assign m_tdata = asc_pkg::M_TDATA_W'({number_class, divisor_sum});

endmodule
`default_nettype wire

[rtl/asc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Aliquot sum classifier: port checker
// Watches the top-level ports and flags handshake and result inconsistencies.
// ----------------------------------------------------------------------------
module asc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [asc_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [asc_pkg::M_TDATA_W-1:0] m_tdata
);

    // A held result word keeps its value until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed or dropped while stalled");

    // One number at a time: after taking a word the input is not ready at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted a second word while busy");

    // Padding bits stay zero and a zero sum is never abundant.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[asc_pkg::M_TDATA_W-1:asc_pkg::PAD_LSB] == '0)
            && ((m_tdata[asc_pkg::CLASS_LSB-1:asc_pkg::SUM_LSB] != '0)
            || (m_tdata[asc_pkg::PAD_LSB-1:asc_pkg::CLASS_LSB]
                != asc_pkg::CLASS_ABUNDANT)))
        else $error("malformed result word");

    // No result is presented in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind aliquot_sum_classifier asc_checker u_asc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
